>>> src/lua_string_comment_range_finder_core_assert.svh
`ifndef LUA_STRING_COMMENT_RANGE_FINDER_CORE_ASSERT_SVH
`define LUA_STRING_COMMENT_RANGE_FINDER_CORE_ASSERT_SVH

// Property that must hold at every rising clock edge outside of the disable condition.
`define LSCRF_ASSERT_ALWAYS(label, clk, dis, prop) \
  label: assert property (@(posedge clk) disable iff (dis) prop) \
    else $error("lscrf: property violated");

// Antecedent in one cycle implies consequent in the next cycle.
`define LSCRF_ASSERT_NEXT(label, clk, dis, ante, cons) \
  label: assert property (@(posedge clk) disable iff (dis) (ante) |=> (cons)) \
    else $error("lscrf: next-cycle property violated");

`endif

>>> src/lscrf_pkg.sv
package lscrf_pkg;

  localparam int POSITION_BITS = 24;
  localparam int FIELD_BITS    = 24;
  localparam int CHAR_BITS     = 16;
  localparam int MODE_BITS     = 4;
  localparam int PEND_BITS     = 3;

  localparam logic [POSITION_BITS-1:0] POS_MAX = {POSITION_BITS{1'b1}};

  // Lexer modes.
  localparam logic [MODE_BITS-1:0] MODE_NORMAL   = 4'd0;
  localparam logic [MODE_BITS-1:0] MODE_SQUOTE   = 4'd1;
  localparam logic [MODE_BITS-1:0] MODE_DQUOTE   = 4'd2;
  localparam logic [MODE_BITS-1:0] MODE_LONGSTR  = 4'd3;
  localparam logic [MODE_BITS-1:0] MODE_LINECOM  = 4'd4;
  localparam logic [MODE_BITS-1:0] MODE_BLOCKCOM = 4'd5;
  localparam logic [MODE_BITS-1:0] MODE_DASH2    = 4'd6;
  localparam logic [MODE_BITS-1:0] MODE_DASH2BR  = 4'd7;

  // Pending lookahead flags.
  localparam logic [PEND_BITS-1:0] PEND_NONE    = 3'd0;
  localparam logic [PEND_BITS-1:0] PEND_DOT     = 3'd1;
  localparam logic [PEND_BITS-1:0] PEND_DASH    = 3'd2;
  localparam logic [PEND_BITS-1:0] PEND_BRACKET = 3'd4;
  localparam logic [PEND_BITS-1:0] PEND_ONE     = 3'd1;

  // Range kinds.
  localparam logic KIND_PROTECTED = 1'b0;
  localparam logic KIND_CONCAT    = 1'b1;

  // Character codes.
  localparam logic [CHAR_BITS-1:0] CH_DOT     = 16'h002E;
  localparam logic [CHAR_BITS-1:0] CH_DASH    = 16'h002D;
  localparam logic [CHAR_BITS-1:0] CH_LBRACK  = 16'h005B;
  localparam logic [CHAR_BITS-1:0] CH_RBRACK  = 16'h005D;
  localparam logic [CHAR_BITS-1:0] CH_DQUOTE  = 16'h0022;
  localparam logic [CHAR_BITS-1:0] CH_SQUOTE  = 16'h0027;
  localparam logic [CHAR_BITS-1:0] CH_BSLASH  = 16'h005C;
  localparam logic [CHAR_BITS-1:0] CH_NEWLINE = 16'h000A;

  typedef struct packed {
    logic [CHAR_BITS-1:0] char_code;
    logic                 end_of_text;
  } char_item_t;

  typedef struct packed {
    logic [FIELD_BITS-1:0] range_start;
    logic [FIELD_BITS-1:0] range_end;
    logic                  range_kind;
    logic                  position_saturated;
  } range_item_t;

  // Handshake between the pipeline stages.
  typedef struct packed {
    logic fire;
    logic emit;
  } step_t;

endpackage

>>> src/lscrf_in_stage.sv
module lscrf_in_stage
  import lscrf_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       char_valid,
  output logic       char_stall,
  input  char_item_t char_item,
  input  logic       advance,
  output logic       held_valid,
  output char_item_t held_item
);

  logic load;

  // The stage refills whenever it is empty or its current transaction moves on.
  assign load       = !held_valid || advance;
  assign char_stall = !load;

  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else if (load) begin
      held_valid <= char_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (load && char_valid) begin
      held_item <= char_item;
    end
  end

endmodule

>>> src/lscrf_lexer.sv
module lscrf_lexer
  import lscrf_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        fire,
  input  char_item_t  item,
  output logic        emit,
  output range_item_t result
);

  logic [MODE_BITS-1:0]     mode, mode_next;
  logic [PEND_BITS-1:0]     pend, pend_next;
  logic [POSITION_BITS-1:0] position, position_next;
  logic [POSITION_BITS-1:0] open_start, open_start_next;

  logic [POSITION_BITS-1:0] endp;
  logic [POSITION_BITS-1:0] prev;
  logic [POSITION_BITS-1:0] r_start;
  logic [POSITION_BITS-1:0] r_end;
  logic                     r_kind;
  logic [CHAR_BITS-1:0]     c;
  logic [CHAR_BITS-1:0]     quote_ch;

  assign c        = item.char_code;
  assign endp     = (position == POS_MAX) ? position : position + 1'b1;
  assign prev     = (position == '0) ? position : position - 1'b1;
  assign quote_ch = (mode == MODE_SQUOTE) ? CH_SQUOTE : CH_DQUOTE;

  always_comb begin
    mode_next       = mode;
    pend_next       = pend;
    open_start_next = open_start;
    position_next   = endp;
    emit            = 1'b0;
    r_start         = open_start;
    r_end           = endp;
    r_kind          = KIND_PROTECTED;

    unique case (mode)
      MODE_SQUOTE, MODE_DQUOTE: begin
        if (pend[0]) begin
          pend_next = PEND_NONE;
        end else if (c == CH_BSLASH) begin
          pend_next = PEND_ONE;
        end else if (c == quote_ch) begin
          mode_next = MODE_NORMAL;
          emit      = 1'b1;
        end
      end
      MODE_LONGSTR, MODE_BLOCKCOM: begin
        if (c == CH_RBRACK) begin
          if (pend[0]) begin
            pend_next = PEND_NONE;
            mode_next = MODE_NORMAL;
            emit      = 1'b1;
          end else begin
            pend_next = PEND_ONE;
          end
        end else begin
          pend_next = PEND_NONE;
        end
      end
      MODE_LINECOM, MODE_DASH2, MODE_DASH2BR: begin
        // A dash pair followed by two brackets opens a block comment;
        // anything else leaves a comment that runs to the newline.
        if (mode == MODE_DASH2 && c == CH_LBRACK) begin
          mode_next = MODE_DASH2BR;
        end else if (mode == MODE_DASH2BR && c == CH_LBRACK) begin
          mode_next = MODE_BLOCKCOM;
        end else if (c == CH_NEWLINE) begin
          mode_next = MODE_NORMAL;
          emit      = 1'b1;
          r_end     = position;
        end else begin
          mode_next = MODE_LINECOM;
        end
      end
      default: begin
        mode_next = MODE_NORMAL;
        pend_next = PEND_NONE;
        if (pend == PEND_DOT && c == CH_DOT) begin
          emit    = 1'b1;
          r_start = prev;
          r_end   = position;
          r_kind  = KIND_CONCAT;
        end else if (pend == PEND_DASH && c == CH_DASH) begin
          mode_next       = MODE_DASH2;
          open_start_next = prev;
        end else if (pend == PEND_BRACKET && c == CH_LBRACK) begin
          mode_next       = MODE_LONGSTR;
          open_start_next = prev;
        end else if (c == CH_DOT) begin
          pend_next = PEND_DOT;
        end else if (c == CH_DASH) begin
          pend_next = PEND_DASH;
        end else if (c == CH_LBRACK) begin
          pend_next = PEND_BRACKET;
        end else if (c == CH_DQUOTE) begin
          mode_next       = MODE_DQUOTE;
          open_start_next = position;
        end else if (c == CH_SQUOTE) begin
          mode_next       = MODE_SQUOTE;
          open_start_next = position;
        end
      end
    endcase

    // At the end of text an open range is closed at the end, and the
    // whole state starts over for the next text.
    if (item.end_of_text) begin
      if (!emit && mode_next != MODE_NORMAL) begin
        emit    = 1'b1;
        r_start = open_start_next;
        r_end   = endp;
        r_kind  = KIND_PROTECTED;
      end
      mode_next       = MODE_NORMAL;
      pend_next       = PEND_NONE;
      open_start_next = '0;
      position_next   = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode       <= MODE_NORMAL;
      pend       <= PEND_NONE;
      position   <= '0;
      open_start <= '0;
    end else if (fire) begin
      mode       <= mode_next;
      pend       <= pend_next;
      position   <= position_next;
      open_start <= open_start_next;
    end
  end

  assign result.range_start        = FIELD_BITS'(r_start);
  assign result.range_end          = FIELD_BITS'(r_end);
  assign result.range_kind         = r_kind;
  assign result.position_saturated = (position == POS_MAX);

endmodule

>>> src/lscrf_out_stage.sv
module lscrf_out_stage
  import lscrf_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  step_t       step,
  input  range_item_t result,
  output logic        advance,
  output logic        range_valid,
  input  logic        range_stall,
  output range_item_t range_item
);

  // The register takes a new result once the current one has gone.
  assign advance = !range_valid || !range_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      range_valid <= 1'b0;
    end else if (advance) begin
      range_valid <= step.fire && step.emit;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && step.fire && step.emit) begin
      range_item <= result;
    end
  end

endmodule

>>> src/lua_string_comment_range_finder_core.sv
// A result passes through the input register, then the result register.
// Throughput: one character per cycle while the result register is not stalled;
// the lexer state update is a single short step, and a character that closes
// nothing yields no transaction.
// Reset (rst, synchronous): both stages empty, normal mode, position zero.
module lua_string_comment_range_finder_core
  import lscrf_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        char_valid,
  output logic        char_stall,
  input  char_item_t  char_item,
  output logic        range_valid,
  input  logic        range_stall,
  output range_item_t range_item
);

  logic        advance;
  logic        held_valid;
  char_item_t  held_item;
  range_item_t result;
  logic        emit;
  step_t       step;

  assign step.fire = held_valid && advance;
  assign step.emit = emit;

  lscrf_in_stage u_in_stage (
    .clk        (clk),
    .rst        (rst),
    .char_valid (char_valid),
    .char_stall (char_stall),
    .char_item  (char_item),
    .advance    (advance),
    .held_valid (held_valid),
    .held_item  (held_item)
  );

  lscrf_lexer u_lexer (
    .clk    (clk),
    .rst    (rst),
    .fire   (step.fire),
    .item   (held_item),
    .emit   (emit),
    .result (result)
  );

  lscrf_out_stage u_out_stage (
    .clk         (clk),
    .rst         (rst),
    .step        (step),
    .result      (result),
    .advance     (advance),
    .range_valid (range_valid),
    .range_stall (range_stall),
    .range_item  (range_item)
  );

endmodule

>>> src/lscrf_checker.sv
`include "lua_string_comment_range_finder_core_assert.svh"

module lscrf_checker
  import lscrf_pkg::*;
(
  input logic        clk,
  input logic        rst,
  input logic        char_stall,
  input logic        range_valid,
  input logic        range_stall,
  input range_item_t range_item
);

  logic out_held;
  logic is_concat;
  logic is_protected;
  logic concat_len_ok;
  logic order_ok;

  assign out_held      = range_valid && range_stall;
  assign is_concat     = range_valid && (range_item.range_kind == KIND_CONCAT);
  assign is_protected  = range_valid && (range_item.range_kind == KIND_PROTECTED);
  assign concat_len_ok = (range_item.range_end == range_item.range_start + FIELD_BITS'(1));
  assign order_ok      = (range_item.range_end >= range_item.range_start);

  // A stalled result transaction keeps its payload.
  `LSCRF_ASSERT_NEXT(a_hold, clk, rst, out_held, range_valid && $stable(range_item))

  // A concatenation pair covers exactly its first dot.
  `LSCRF_ASSERT_ALWAYS(a_concat_len, clk, rst, is_concat |-> concat_len_ok)

  // Protected ranges never end before they start.
  `LSCRF_ASSERT_ALWAYS(a_order, clk, rst, is_protected |-> order_ok)

  // Reset empties the result register and leaves the input side ready.
  `LSCRF_ASSERT_NEXT(a_reset, clk, 1'b0, rst, !range_valid && !char_stall)

endmodule

bind lua_string_comment_range_finder_core lscrf_checker u_checker (.*);

>>> test/testbench.sv
`timescale 1ns / 1ps

module testbench;
  import lscrf_pkg::*;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        char_valid = 1'b0;
  logic        char_stall;
  char_item_t  char_item = '0;
  logic        range_valid;
  logic        range_stall = 1'b0;
  range_item_t range_item;

  lua_string_comment_range_finder_core DUT (
    .clk        (clk),
    .rst        (rst),
    .char_valid (char_valid),
    .char_stall (char_stall),
    .char_item  (char_item),
    .range_valid(range_valid),
    .range_stall(range_stall),
    .range_item (range_item)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Lexer state mirrored from the block.
  logic [MODE_BITS-1:0]     lex_mode   = MODE_NORMAL;
  logic [POSITION_BITS-1:0] char_pos   = '0;
  logic [POSITION_BITS-1:0] span_start = '0;
  logic [PEND_BITS-1:0]     lex_pend   = PEND_NONE;

  range_item_t              expected_ranges[$];
  logic [CHAR_BITS-1:0]     src_text[$];
  int                       mismatch_count = 0;
  int                       chars_sent = 0;
  int                       send_idle_pct = 0;
  int                       recv_idle_pct = 0;
  int                       recv_hold_req = 0;
  int                       hold_left = 0;

  initial begin
    #2_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  function automatic void add_code(input logic [CHAR_BITS-1:0] code);
    src_text.insert(src_text.size(), code);
  endfunction

  function automatic range_item_t make_range(input logic [POSITION_BITS-1:0] first,
                                             input logic [POSITION_BITS-1:0] past,
                                             input logic kind);
    range_item_t r;
    r.range_start        = first;
    r.range_end          = past;
    r.range_kind         = kind;
    r.position_saturated = (char_pos == POS_MAX);
    return r;
  endfunction

  // Inside a line comment only a newline matters; the range stops before it.
  function automatic bit comment_char(input logic [CHAR_BITS-1:0] c, output range_item_t rng);
    lex_mode = MODE_LINECOM;
    rng = '0;
    if (c == CH_NEWLINE) begin
      lex_mode = MODE_NORMAL;
      rng = make_range(span_start, char_pos, KIND_PROTECTED);
      return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic bit scan_char(input char_item_t ch, output range_item_t rng);
    logic [CHAR_BITS-1:0]     c;
    logic [POSITION_BITS-1:0] next_pos;
    logic [POSITION_BITS-1:0] prev_pos;
    bit                       hit;
    c        = ch.char_code;
    next_pos = (char_pos == POS_MAX) ? char_pos : char_pos + 1'b1;
    prev_pos = (char_pos != '0) ? char_pos - 1'b1 : '0;
    hit      = 1'b0;
    rng      = '0;
    case (lex_mode)
      MODE_SQUOTE, MODE_DQUOTE: begin
        if ((lex_pend & PEND_ONE) != PEND_NONE) begin
          lex_pend = PEND_NONE;
        end else if (c == CH_BSLASH) begin
          lex_pend = PEND_ONE;
        end else if (c == ((lex_mode == MODE_SQUOTE) ? CH_SQUOTE : CH_DQUOTE)) begin
          lex_mode = MODE_NORMAL;
          rng = make_range(span_start, next_pos, KIND_PROTECTED);
          hit = 1'b1;
        end
      end
      MODE_LONGSTR, MODE_BLOCKCOM: begin
        if (c == CH_RBRACK) begin
          if ((lex_pend & PEND_ONE) != PEND_NONE) begin
            lex_pend = PEND_NONE;
            lex_mode = MODE_NORMAL;
            rng = make_range(span_start, next_pos, KIND_PROTECTED);
            hit = 1'b1;
          end else begin
            lex_pend = PEND_ONE;
          end
        end else begin
          lex_pend = PEND_NONE;
        end
      end
      MODE_LINECOM: hit = comment_char(c, rng);
      MODE_DASH2: begin
        if (c == CH_LBRACK) lex_mode = MODE_DASH2BR;
        else hit = comment_char(c, rng);
      end
      MODE_DASH2BR: begin
        if (c == CH_LBRACK) lex_mode = MODE_BLOCKCOM;
        else hit = comment_char(c, rng);
      end
      default: begin
        lex_mode = MODE_NORMAL;
        if (lex_pend == PEND_DOT && c == CH_DOT) begin
          lex_pend = PEND_NONE;
          rng = make_range(prev_pos, char_pos, KIND_CONCAT);
          hit = 1'b1;
        end else if (lex_pend == PEND_DASH && c == CH_DASH) begin
          lex_pend   = PEND_NONE;
          lex_mode   = MODE_DASH2;
          span_start = prev_pos;
        end else if (lex_pend == PEND_BRACKET && c == CH_LBRACK) begin
          lex_pend   = PEND_NONE;
          lex_mode   = MODE_LONGSTR;
          span_start = prev_pos;
        end else begin
          lex_pend = PEND_NONE;
          if (c == CH_DOT) lex_pend = PEND_DOT;
          else if (c == CH_DASH) lex_pend = PEND_DASH;
          else if (c == CH_LBRACK) lex_pend = PEND_BRACKET;
          else if (c == CH_DQUOTE) begin
            lex_mode   = MODE_DQUOTE;
            span_start = char_pos;
          end else if (c == CH_SQUOTE) begin
            lex_mode   = MODE_SQUOTE;
            span_start = char_pos;
          end
        end
      end
    endcase

    if (ch.end_of_text) begin
      if (!hit && lex_mode != MODE_NORMAL) begin
        rng = make_range(span_start, next_pos, KIND_PROTECTED);
        hit = 1'b1;
      end
      lex_mode   = MODE_NORMAL;
      char_pos   = '0;
      span_start = '0;
      lex_pend   = PEND_NONE;
    end else begin
      char_pos = next_pos;
    end
    return hit;
  endfunction

  function automatic void compare_field(input string name, input logic [FIELD_BITS-1:0] want,
                                        input logic [FIELD_BITS-1:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
      mismatch_count++;
    end
  endfunction

  // Result side: checks each accepted transaction and drives the stall.
  always @(posedge clk) begin
    range_item_t want;
    if (!rst && range_valid && !range_stall) begin
      if (expected_ranges.size() == 0) begin
        $display("%0t: unexpected range, expected none, actual start %0h end %0h kind %0b",
                 $time, range_item.range_start, range_item.range_end, range_item.range_kind);
        mismatch_count++;
      end else begin
        want = expected_ranges.pop_front();
        compare_field("range_start", want.range_start, range_item.range_start);
        compare_field("range_end", want.range_end, range_item.range_end);
        compare_field("range_kind", FIELD_BITS'(want.range_kind),
                      FIELD_BITS'(range_item.range_kind));
        compare_field("position_saturated", FIELD_BITS'(want.position_saturated),
                      FIELD_BITS'(range_item.position_saturated));
      end
    end
    if (recv_hold_req > 0) begin
      hold_left     = recv_hold_req;
      recv_hold_req = 0;
    end
    if (hold_left > 0) begin
      hold_left--;
      range_stall <= 1'b1;
    end else begin
      range_stall <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  task automatic send_char(input logic [CHAR_BITS-1:0] code, input logic is_last);
    char_item_t  item;
    range_item_t rng;
    item.char_code   = code;
    item.end_of_text = is_last;
    if ($urandom_range(99) < send_idle_pct) begin
      char_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    char_valid <= 1'b1;
    char_item  <= item;
    @(posedge clk);
    while (char_stall) @(posedge clk);
    if (scan_char(item, rng)) expected_ranges.insert(expected_ranges.size(), rng);
    chars_sent++;
  endtask

  task automatic send_text();
    for (int i = 0; i < src_text.size(); i++) send_char(src_text[i], i == src_text.size() - 1);
  endtask

  task automatic send_string(input string s);
    src_text.delete();
    for (int i = 0; i < s.len(); i++) add_code(CHAR_BITS'(s[i]));
    send_text();
  endtask

  // The valid is dropped first so that the last character is not offered twice.
  task automatic wait_for_results();
    char_valid <= 1'b0;
    do @(posedge clk); while (expected_ranges.size() != 0);
  endtask

  function automatic logic [CHAR_BITS-1:0] special_char();
    case ($urandom_range(7))
      0: return CH_DOT;
      1: return CH_DASH;
      2: return CH_LBRACK;
      3: return CH_RBRACK;
      4: return CH_DQUOTE;
      5: return CH_SQUOTE;
      6: return CH_BSLASH;
      default: return CH_NEWLINE;
    endcase
  endfunction

  function automatic logic [CHAR_BITS-1:0] fill_char();
    logic [CHAR_BITS-1:0] code;
    case ($urandom_range(15))
      0, 1, 2, 3, 4, 5: code = special_char();
      6: code = 16'($urandom);
      7: begin
        // Same low byte as a special character, so only a full compare tells them apart.
        code = special_char();
        code[15:8] = 8'($urandom_range(1, 255));
      end
      default: code = 16'h0061 + 16'($urandom_range(25));
    endcase
    return code;
  endfunction

  function automatic void add_piece();
    logic [CHAR_BITS-1:0] quote;
    int                   len;
    len = $urandom_range(0, 6);
    case ($urandom_range(11))
      0, 1: begin
        quote = $urandom_range(1) ? CH_DQUOTE : CH_SQUOTE;
        add_code(quote);
        repeat (len) begin
          if ($urandom_range(4) == 0) add_code(CH_BSLASH);
          add_code(fill_char());
        end
        if ($urandom_range(7) != 0) add_code(quote);
      end
      2: begin
        add_code(CH_LBRACK);
        add_code(CH_LBRACK);
        repeat (len) add_code(fill_char());
        if ($urandom_range(7) != 0) begin
          add_code(CH_RBRACK);
          add_code(CH_RBRACK);
        end
      end
      3: begin
        add_code(CH_DASH);
        add_code(CH_DASH);
        repeat (len) add_code(fill_char());
        add_code(CH_NEWLINE);
      end
      4: begin
        add_code(CH_DASH);
        add_code(CH_DASH);
        add_code(CH_LBRACK);
        if ($urandom_range(5) != 0) add_code(CH_LBRACK);
        repeat (len) add_code(fill_char());
        add_code(CH_RBRACK);
        add_code(CH_RBRACK);
      end
      5: repeat ($urandom_range(1, 5)) add_code(CH_DOT);
      6: repeat (len + 1) add_code(16'h0061 + 16'($urandom_range(25)));
      7: add_code($urandom_range(1) ? CH_NEWLINE : 16'h0020);
      default: repeat ($urandom_range(1, 3)) add_code(fill_char());
    endcase
  endfunction

  task automatic test_directed_cases();
    send_string("--[[]]");
    send_string("[[]");
    send_string("'\\''");
    send_string("\"\\");
    send_string("--[\n");
    send_string("...");
    send_char(16'hFFFF, 1'b1);
    send_char(16'h0000, 1'b1);
    wait_for_results();
  endtask

  // Long receiver hold while a run of dot pairs keeps the results coming.
  task automatic test_output_backpressure();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    recv_hold_req = 60;
    src_text.delete();
    repeat (40) add_code(CH_DOT);
    send_text();
    wait_for_results();
  endtask

  task automatic test_random_texts(input int item_count);
    int goal;
    goal = chars_sent + item_count;
    while (chars_sent < goal) begin
      src_text.delete();
      repeat ($urandom_range(1, 8)) add_piece();
      send_text();
      if ($urandom_range(19) == 0) wait_for_results();
    end
    wait_for_results();
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    test_directed_cases();
    test_output_backpressure();
    send_idle_pct = 18;
    recv_idle_pct = 76;
    test_random_texts(420);
    send_idle_pct = 76;
    recv_idle_pct = 18;
    test_random_texts(420);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random_texts(420);
    repeat (20) @(posedge clk);
    if (mismatch_count == 0 && expected_ranges.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
